@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a property that must hold at every rising clock edge outside reset
`define TSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// an implication checked on the following clock edge
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/tsc_pkg.sv @@
// package of types, constants and helpers for the two slot score cache
`default_nettype none
package tsc_pkg;
  localparam int unsigned IndexBits  = 12;
  localparam int unsigned EntryCount = 1 << IndexBits;
  localparam logic signed [7:0] EmptyDepth = -8'sd2;
  localparam logic [1:0] BoundExact   = 2'd0;
  localparam logic [1:0] BoundUpper   = 2'd1;
  localparam logic [1:0] BoundLower   = 2'd2;
  localparam logic [1:0] BoundUnknown = 2'd3;
  localparam logic [30:0] MateThrReset = 31'd100000;

  typedef enum logic [2:0] {
    KindProbe  = 3'd0,
    KindRecord = 3'd1,
    KindBest   = 3'd2,
    KindDepth  = 3'd3,
    KindAlways = 3'd4,
    KindClear  = 3'd5
  } kind_e;

  localparam logic CfgMateThr = 1'b0;
  localparam logic CfgEmptyMove = 1'b1;

  typedef logic [IndexBits-1:0] index_t;

  // one slot of an entry
  typedef struct packed {
    logic [63:0]       key;
    logic signed [7:0] depth;
    logic [1:0]        bound;
    logic signed [31:0] score;
    logic [31:0]       move;
  } slot_t;

  // one command word queued between front and back
  typedef struct packed {
    logic [2:0]         kind;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] score;
    logic [1:0]         bound;
    logic [31:0]        move;
    logic [7:0]         ply;
  } cmd_t;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/tsc_front.sv @@
// front end: accepts words, drops unused kinds and timed-out records, holds a two-deep command queue
`default_nettype none
module tsc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tsc_pkg::cmd_t  in_cmd_i,
  input  wire logic           in_time_over_i,
  output logic                cmd_valid_o,
  output tsc_pkg::cmd_t       cmd_o,
  input  wire logic           cmd_pop_i
);
  tsc_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic push, keep;

  assign in_stall = (cnt_q == 2'd2);
  // record with time over and unused kinds leave no trace
  assign keep = (in_cmd_i.kind <= 3'(tsc_pkg::KindClear)) &&
                !(in_cmd_i.kind == 3'(tsc_pkg::KindRecord) && in_time_over_i);
  assign push = in_valid && !in_stall && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[0];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_i) begin
      q_q[0] <= q_q[1];
      if (push && cnt_q == 2'd2) q_q[1] <= in_cmd_i;
      if (push && cnt_q == 2'd1) q_q[0] <= in_cmd_i;
    end else if (push) begin
      if (cnt_q == 2'd0) q_q[0] <= in_cmd_i;
      else q_q[1] <= in_cmd_i;
    end
  end

  `include "assert_macros.svh"
  `TSC_ASSERT(a_pop_nonempty, clk_i, rst_ni, !cmd_pop_i || cnt_q != 2'd0, "pop from empty queue")
  `TSC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count overflow")
  `TSC_ASSERT(a_no_push_full, clk_i, rst_ni, !(push && cnt_q == 2'd2), "push into full queue")
endmodule
`default_nettype wire

@@ rtl/core/tsc_back.sv @@
// back end: table memory, read-modify-write sequencer, clear walk, output register
`default_nettype none
module tsc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [30:0]   mate_thr_i,
  input  wire logic [31:0]   empty_move_i,
  input  wire logic          cmd_valid_i,
  input  wire tsc_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               clearing_o,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               score_hit_o,
  output logic [31:0]        score_o,
  output logic               move_found_o,
  output logic [31:0]        found_move_o
);
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRead  = 4'b0010,
    StEval  = 4'b0100,
    StClear = 4'b1000
  } state_e;

  state_e state_q, state_d;
  tsc_pkg::slot_t mem0 [tsc_pkg::EntryCount];
  tsc_pkg::slot_t mem1 [tsc_pkg::EntryCount];
  tsc_pkg::slot_t rd0_q, rd1_q;
  tsc_pkg::cmd_t  cur_q;
  tsc_pkg::index_t clr_q, clr_d;
  tsc_pkg::index_t widx;
  logic we0, we1;
  tsc_pkg::slot_t wdata;
  logic res_load;
  logic hit_n, found_n;
  logic signed [31:0] score_n;
  logic [31:0] fmove_n;
  logic signed [31:0] rec_score;
  logic signed [32:0] thr;

  assign thr = {2'b00, mate_thr_i};
  assign clearing_o = (state_q == StClear);

  // probe score of one slot, with mate shift undone
  function automatic logic signed [31:0] unshift(input logic signed [31:0] s,
      input logic [7:0] p, input logic signed [32:0] t);
    logic signed [31:0] r;
    r = s;
    if (33'(s) > t) r = tsc_pkg::sat32(34'(s) - 34'(p));
    else if (33'(s) < -t) r = tsc_pkg::sat32(34'(s) + 34'(p));
    return r;
  endfunction

  function automatic logic usable(input tsc_pkg::slot_t sl, input tsc_pkg::cmd_t c,
      input logic signed [31:0] sc);
    return sl.key == c.key && sl.depth >= c.depth &&
           (sl.bound == tsc_pkg::BoundExact ||
            (sl.bound == tsc_pkg::BoundUpper && sc <= c.alpha) ||
            (sl.bound == tsc_pkg::BoundLower && sc >= c.beta));
  endfunction

  always_comb begin
    logic signed [31:0] s0, s1, sc;
    s0 = unshift(rd0_q.score, cur_q.ply, thr);
    s1 = unshift(rd1_q.score, cur_q.ply, thr);
    hit_n = 1'b0;
    found_n = 1'b0;
    score_n = '0;
    fmove_n = empty_move_i;
    sc = s1;
    if (cur_q.kind == 3'(tsc_pkg::KindProbe)) begin
      if (usable(rd0_q, cur_q, s0)) begin
        hit_n = 1'b1;
        sc = s0;
      end else if (usable(rd1_q, cur_q, s1)) begin
        hit_n = 1'b1;
      end
      if (sc < cur_q.alpha) sc = cur_q.alpha;
      if (sc > cur_q.beta) sc = cur_q.beta;
      if (hit_n) score_n = sc;
    end else if (cur_q.kind == 3'(tsc_pkg::KindBest)) begin
      if (rd0_q.key == cur_q.key && rd0_q.move != empty_move_i) begin
        found_n = 1'b1;
        fmove_n = rd0_q.move;
      end else if (rd1_q.key == cur_q.key) begin
        found_n = 1'b1;
        fmove_n = rd1_q.move;
      end
    end else if (cur_q.kind == 3'(tsc_pkg::KindDepth)) begin
      if (rd0_q.key == cur_q.key) begin
        found_n = 1'b1;
        fmove_n = rd0_q.move;
      end
    end else if (rd1_q.key == cur_q.key) begin
      found_n = 1'b1;
      fmove_n = rd1_q.move;
    end
  end

  always_comb begin
    rec_score = cur_q.score;
    if (33'(cur_q.score) > thr) rec_score = tsc_pkg::sat32(34'(cur_q.score) + 34'(cur_q.ply));
    else if (33'(cur_q.score) < -thr)
      rec_score = tsc_pkg::sat32(34'(cur_q.score) - 34'(cur_q.ply));
  end

  always_comb begin
    state_d = state_q;
    cmd_pop_o = 1'b0;
    res_load = 1'b0;
    we0 = 1'b0;
    we1 = 1'b0;
    widx = cur_q.key[tsc_pkg::IndexBits-1:0];
    wdata = '{key: cur_q.key, depth: cur_q.depth, bound: cur_q.bound,
              score: rec_score, move: cur_q.move};
    clr_d = clr_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == 3'(tsc_pkg::KindClear)) begin
            state_d = StClear;
            clr_d = '0;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: state_d = StEval;
      StEval: begin
        if (cur_q.kind == 3'(tsc_pkg::KindRecord)) begin
          we0 = rd0_q.depth <= cur_q.depth;
          we1 = 1'b1;
          state_d = StIdle;
        end else if (!out_valid || !out_stall) begin
          res_load = 1'b1;
          state_d = StIdle;
        end
      end
      StClear: begin
        widx = clr_q;
        wdata = '{key: '0, depth: tsc_pkg::EmptyDepth, bound: tsc_pkg::BoundUnknown,
                  score: '0, move: empty_move_i};
        we0 = 1'b1;
        we1 = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = StIdle;
          clr_d = '0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      out_valid <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    if (state_q == StRead) begin
      rd0_q <= mem0[cur_q.key[tsc_pkg::IndexBits-1:0]];
      rd1_q <= mem1[cur_q.key[tsc_pkg::IndexBits-1:0]];
    end
    if (we0) mem0[widx] <= wdata;
    if (we1) mem1[widx] <= wdata;
    if (res_load) begin
      score_hit_o <= hit_n;
      score_o <= score_n;
      move_found_o <= found_n;
      found_move_o <= fmove_n;
    end
  end

  `include "assert_macros.svh"
  `TSC_ASSERT(a_no_load_stalled, clk_i, rst_ni, !(res_load && out_valid && out_stall),
              "result register overwritten while stalled")
  `TSC_ASSERT_NEXT(a_read_eval, clk_i, rst_ni, state_q == StRead, state_q == StEval,
                   "read not followed by evaluation")
  `TSC_ASSERT(a_no_pop_busy, clk_i, rst_ni, !cmd_pop_o || state_q == StIdle,
              "command taken while busy")
endmodule
`default_nettype wire

@@ rtl/core/two_slot_score_cache.sv @@
// two slot score cache: a two-tier position table with a decoupled front and back
// After reset the block walks all 4096 entries (one per cycle) to empty them before
// taking words; a clear word repeats that walk. Probe, record and move queries go
// through the back end as dequeue, memory read, then evaluate and write back, set
// by the single read-modify-write port of the entry memory, with no new word taken
// until the last is through; a two-word queue lets the input side run ahead. Records
// with time over and unused kinds are dropped at the front and produce no word.
// Config writes are taken at any time but should be made only while idle.
`default_nettype none
module two_slot_score_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] hash_key_i,
  input  wire logic [7:0]  search_depth_i,
  input  wire logic [31:0] alpha_i,
  input  wire logic [31:0] beta_i,
  input  wire logic [31:0] new_score_i,
  input  wire logic [1:0]  bound_kind_i,
  input  wire logic [31:0] new_move_i,
  input  wire logic [7:0]  ply_i,
  input  wire logic        time_over_i,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             score_hit_o,
  output logic [31:0]      score_o,
  output logic             move_found_o,
  output logic [31:0]      found_move_o
);
  logic [30:0] mate_thr_q;
  logic [31:0] empty_move_q;
  tsc_pkg::cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_pop, clearing, front_stall;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_thr_q <= tsc_pkg::MateThrReset;
      empty_move_q <= '0;
    end else if (cfg_valid) begin
      if (cfg_index_i[0] == tsc_pkg::CfgMateThr) mate_thr_q <= cfg_data_i[30:0];
      else empty_move_q <= cfg_data_i;
    end
  end

  assign in_cmd = '{kind: kind_i, key: hash_key_i, depth: search_depth_i,
                    alpha: alpha_i, beta: beta_i, score: new_score_i,
                    bound: bound_kind_i, move: new_move_i, ply: ply_i};

  // no words are taken during the clearing walk
  logic front_valid;
  assign front_valid = in_valid && !clearing;
  assign in_stall = front_stall || clearing;

  tsc_front u_front (
    .clk_i, .rst_ni,
    .in_valid (front_valid), .in_stall (front_stall),
    .in_cmd_i (in_cmd), .in_time_over_i (time_over_i),
    .cmd_valid_o (cmd_valid), .cmd_o (cmd), .cmd_pop_i (cmd_pop)
  );

  tsc_back u_back (
    .clk_i, .rst_ni,
    .mate_thr_i (mate_thr_q), .empty_move_i (empty_move_q),
    .cmd_valid_i (cmd_valid), .cmd_i (cmd), .cmd_pop_o (cmd_pop),
    .clearing_o (clearing),
    .out_valid, .out_stall,
    .score_hit_o, .score_o, .move_found_o, .found_move_o
  );
endmodule
`default_nettype wire

@@ tb/sv/two_slot_score_cache_tb.sv @@
// self-checking testbench for the two slot score cache
`default_nettype none
module two_slot_score_cache_tb;

  // spare kind codes that the block must drop without a result word
  localparam logic [2:0] KindSpareA = 3'd6;
  localparam logic [2:0] KindSpareB = 3'd7;
  // a clear walks every entry, so give it this long before touching config
  localparam int unsigned WalkWait = tsc_pkg::EntryCount + 100;

  // one input word as the driver presents it
  typedef struct {
    logic [2:0]         kind;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] score;
    logic [1:0]         bound;
    logic [31:0]        move;
    logic [7:0]         ply;
    logic               time_over;
  } query_t;

  // one answer word
  typedef struct {
    logic        hit;
    logic [31:0] score;
    logic        found;
    logic [31:0] move;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind_i = '0;
  logic [63:0] hash_key_i = '0;
  logic [7:0] search_depth_i = '0;
  logic [31:0] alpha_i = '0;
  logic [31:0] beta_i = '0;
  logic [31:0] new_score_i = '0;
  logic [1:0] bound_kind_i = '0;
  logic [31:0] new_move_i = '0;
  logic [7:0] ply_i = '0;
  logic time_over_i = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic score_hit_o;
  logic [31:0] score_o;
  logic move_found_o;
  logic [31:0] found_move_o;

  two_slot_score_cache dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind_i         (kind_i),
    .hash_key_i     (hash_key_i),
    .search_depth_i (search_depth_i),
    .alpha_i        (alpha_i),
    .beta_i         (beta_i),
    .new_score_i    (new_score_i),
    .bound_kind_i   (bound_kind_i),
    .new_move_i     (new_move_i),
    .ply_i          (ply_i),
    .time_over_i    (time_over_i),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .score_hit_o    (score_hit_o),
    .score_o        (score_o),
    .move_found_o   (move_found_o),
    .found_move_o   (found_move_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the table and the two registers
  logic [63:0]        tab_key   [2][tsc_pkg::EntryCount];
  logic signed [7:0]  tab_depth [2][tsc_pkg::EntryCount];
  logic [1:0]         tab_bound [2][tsc_pkg::EntryCount];
  logic signed [31:0] tab_score [2][tsc_pkg::EntryCount];
  logic [31:0]        tab_move  [2][tsc_pkg::EntryCount];
  logic [30:0] mate_thr = tsc_pkg::MateThrReset;
  logic [31:0] no_move = '0;

  query_t  pending_q[$];   // words not yet presented
  answer_t answers_q[$];   // answers owed by the block
  query_t  cur_word;       // word currently on the input port
  int unsigned issued_n = 0, accepted_n = 0, answered_n = 0, hits_n = 0, found_n = 0;
  int unsigned fails = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  logic [63:0] hi_pool[4];
  logic [11:0] idx_pool[6];

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void wipe_table();
    for (int e = 0; e < tsc_pkg::EntryCount; e++) begin
      for (int s = 0; s < 2; s++) begin
        tab_key[s][e] = '0;
        tab_depth[s][e] = tsc_pkg::EmptyDepth;
        tab_bound[s][e] = tsc_pkg::BoundUnknown;
        tab_score[s][e] = '0;
        tab_move[s][e] = no_move;
      end
    end
  endfunction

  // apply one accepted word to the shadow table and queue its answer, if any
  function automatic void apply_word(query_t w);
    tsc_pkg::index_t ix;
    longint  thr, val, lo, hi;
    answer_t a;
    ix = w.key[tsc_pkg::IndexBits-1:0];
    thr = longint'(mate_thr);
    lo = longint'(w.alpha);
    hi = longint'(w.beta);
    a = '{hit: 1'b0, score: '0, found: 1'b0, move: no_move};
    case (w.kind)
      tsc_pkg::KindRecord: begin
        if (w.time_over) return;
        val = longint'(w.score);
        // mate scores move away from zero by ply
        if (val > thr) val = sat_s32(val + longint'(w.ply));
        else if (val < -thr) val = sat_s32(val - longint'(w.ply));
        for (int s = 0; s < 2; s++) begin
          if (s == 1 || tab_depth[0][ix] <= w.depth) begin
            tab_key[s][ix] = w.key;
            tab_move[s][ix] = w.move;
            tab_score[s][ix] = 32'(val);
            tab_bound[s][ix] = w.bound;
            tab_depth[s][ix] = w.depth;
          end
        end
        return;
      end
      tsc_pkg::KindClear: begin
        wipe_table();
        return;
      end
      tsc_pkg::KindProbe: begin
        for (int s = 0; s < 2; s++) begin
          if (!a.hit && tab_key[s][ix] == w.key && tab_depth[s][ix] >= w.depth) begin
            val = longint'(tab_score[s][ix]);
            if (val > thr) val = sat_s32(val - longint'(w.ply));
            else if (val < -thr) val = sat_s32(val + longint'(w.ply));
            if (tab_bound[s][ix] == tsc_pkg::BoundExact ||
                (tab_bound[s][ix] == tsc_pkg::BoundUpper && val <= lo) ||
                (tab_bound[s][ix] == tsc_pkg::BoundLower && val >= hi)) begin
              if (val < lo) val = lo;
              if (val > hi) val = hi;
              a.hit = 1'b1;
              a.score = 32'(val);
            end
          end
        end
      end
      tsc_pkg::KindBest: begin
        if (tab_key[0][ix] == w.key && tab_move[0][ix] != no_move) begin
          a.found = 1'b1;
          a.move = tab_move[0][ix];
        end else if (tab_key[1][ix] == w.key) begin
          a.found = 1'b1;
          a.move = tab_move[1][ix];
        end
      end
      tsc_pkg::KindDepth, tsc_pkg::KindAlways: begin
        if (tab_key[w.kind == tsc_pkg::KindAlways][ix] == w.key) begin
          a.found = 1'b1;
          a.move = tab_move[w.kind == tsc_pkg::KindAlways][ix];
        end
      end
      default: return;  // spare kinds are dropped
    endcase
    answers_q.push_back(a);
  endfunction

  // driver: new word or idle at the falling edge, held while stalled
  always @(negedge clk_i) begin
    if (in_valid && accepted_n != issued_n) begin
      // still waiting for the current word to be taken
    end else if (rst_ni && pending_q.size() > 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      cur_word = pending_q.pop_front();
      issued_n++;
      kind_i <= cur_word.kind;
      hash_key_i <= cur_word.key;
      search_depth_i <= cur_word.depth;
      alpha_i <= cur_word.alpha;
      beta_i <= cur_word.beta;
      new_score_i <= cur_word.score;
      bound_kind_i <= cur_word.bound;
      new_move_i <= cur_word.move;
      ply_i <= cur_word.ply;
      time_over_i <= cur_word.time_over;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        accepted_n++;
        apply_word(cur_word);
      end
      if (out_valid && !out_stall) begin
        answered_n++;
        if (answers_q.size() == 0) begin
          $error("answer word with nothing outstanding");
          fails++;
        end else begin
          exp_a = answers_q.pop_front();
          hits_n += exp_a.hit;
          found_n += exp_a.found;
          if (score_hit_o !== exp_a.hit) begin
            $error("score_hit: expected %0d, got %0d", exp_a.hit, score_hit_o);
            fails++;
          end
          if (score_o !== exp_a.score) begin
            $error("score: expected %0d, got %0d", $signed(exp_a.score), $signed(score_o));
            fails++;
          end
          if (move_found_o !== exp_a.found) begin
            $error("move_found: expected %0d, got %0d", exp_a.found, move_found_o);
            fails++;
          end
          if (found_move_o !== exp_a.move) begin
            $error("found_move: expected %h, got %h", exp_a.move, found_move_o);
            fails++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == tsc_pkg::CfgMateThr) mate_thr = data[30:0];
    else no_move = data;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // everything presented, taken and answered, then room for a trailing clear
  task automatic drain();
    while (pending_q.size() != 0 || accepted_n != issued_n || answers_q.size() != 0)
      @(posedge clk_i);
    repeat (WalkWait) @(posedge clk_i);
  endtask

  function automatic query_t make_word(logic [2:0] k, logic [63:0] key, int dep,
                                       logic [31:0] sc, logic [1:0] bnd, logic [31:0] mv,
                                       logic [7:0] pl, logic [31:0] lo, logic [31:0] hi,
                                       logic tmo);
    query_t w;
    w.kind = k; w.key = key; w.depth = 8'(dep); w.score = sc; w.bound = bnd;
    w.move = mv; w.ply = pl; w.alpha = lo; w.beta = hi; w.time_over = tmo;
    return w;
  endfunction

  function automatic logic [31:0] pick_score();
    int unsigned r;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    t = {1'b0, mate_thr} + $urandom_range(0, 2) - 1;
    if (r < 25) return 32'($signed($urandom_range(0, 4000)) - 2000);
    if (r < 50) return ($urandom_range(0, 1)) ? t : -t;
    if (r < 65) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'h8000_0000 + $urandom_range(0, 3);
    return $urandom;
  endfunction

  // mostly a small set of keys so that records and queries meet
  function automatic query_t rand_word();
    query_t w;
    int unsigned r;
    logic [31:0] a;
    r = $urandom_range(0, 999);
    if (r < 330) w.kind = tsc_pkg::KindProbe;
    else if (r < 690) w.kind = tsc_pkg::KindRecord;
    else if (r < 780) w.kind = tsc_pkg::KindBest;
    else if (r < 860) w.kind = tsc_pkg::KindDepth;
    else if (r < 940) w.kind = tsc_pkg::KindAlways;
    else if (r < 997) w.kind = ($urandom_range(0, 1)) ? KindSpareA : KindSpareB;
    else w.kind = tsc_pkg::KindClear;
    if ($urandom_range(0, 9) == 0) w.key = {$urandom, $urandom};
    else w.key = {hi_pool[$urandom_range(0, 3)][63:12], idx_pool[$urandom_range(0, 5)]};
    w.depth = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8) - 2) : 8'($urandom);
    w.score = pick_score();
    w.bound = $urandom_range(0, 9) == 0 ? tsc_pkg::BoundUnknown : 2'($urandom_range(0, 2));
    r = $urandom_range(0, 9);
    w.move = r < 2 ? no_move : r < 3 ? 32'hFFFF_FFFF : r < 4 ? 32'h0 : $urandom;
    w.ply = $urandom;
    w.time_over = $urandom_range(0, 99) < 8;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      a = pick_score();
      w.alpha = a;
      w.beta = 32'(sat_s32(longint'($signed(a)) + $urandom_range(0, 5000)));
    end else if (r < 8) begin
      w.alpha = 32'h8000_0000;
      w.beta = 32'h7FFF_FFFF;
    end else begin
      w.alpha = $urandom;
      w.beta = $urandom;
    end
    return w;
  endfunction

  initial begin
    int unsigned stall_mix[4][2];
    logic [31:0] thr_set[4], code_set[4];
    stall_mix = '{'{0, 0}, '{57, 0}, '{0, 57}, '{18, 18}};
    hi_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom}};
    idx_pool = '{12'h000, 12'h001, 12'h002, 12'hFFF, 12'($urandom), 12'($urandom)};
    thr_set = '{100000, 0, 32'h7FFF_FFFF, $urandom_range(50, 5000)};
    code_set = '{0, 32'hFFFF_FFFF, $urandom, 1};
    wipe_table();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // the block empties its table after reset before taking words
    repeat (WalkWait) @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tsc_pkg::CfgMateThr, thr_set[ph]);
      write_reg(tsc_pkg::CfgEmptyMove, code_set[ph]);
      send_idle_pct = stall_mix[ph][0];
      recv_stall_pct = stall_mix[ph][1];
      if (ph == 0) begin
        // empty table: key 0 matches both slots but bound unknown never hits
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 0, -128, 0, 0, 0, 0,
                                      32'h8000_0000, 32'h7FFF_FFFF, 0));
        pending_q.push_back(make_word(tsc_pkg::KindBest, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindDepth, 64'h55, 0, 0, 0, 0, 0, 0, 0, 0));
        // exact record, then a hit, a miss at greater depth and a hit with inverted window
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'h10, 5, 300,
                                      tsc_pkg::BoundExact, 32'h77, 3, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h10, 5, 0, 0, 0, 3,
                                      -1000, 1000, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h10, 6, 0, 0, 0, 3,
                                      -1000, 1000, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h10, 1, 0, 0, 0, 0,
                                      500, 100, 0));
        // shallower record only lands in the always slot
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'h1_0000_0010, 2, -7,
                                      tsc_pkg::BoundUpper, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindBest, 64'h1_0000_0010, 0, 0, 0, 0, 0,
                                      0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindAlways, 64'h1_0000_0010, 0, 0, 0, 0, 0,
                                      0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindDepth, 64'h10, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h1_0000_0010, 2, 0, 0, 0, 0,
                                      -7, 50, 0));
        // mate scores with saturation at both ends
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'hFFFF_FFFF_FFFF_FFFF, 127,
                                      32'h7FFF_FFF0, tsc_pkg::BoundLower, 32'hFFFF_FFFF,
                                      255, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'hFFFF_FFFF_FFFF_FFFF, 127, 0,
                                      0, 0, 255, 0, 32'h7FFF_FF00, 0));
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'h20, 3, 32'h8000_0005,
                                      tsc_pkg::BoundExact, 9, 200, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h20, -128, 0, 0, 0, 10,
                                      32'h8000_0000, 32'h7FFF_FFFF, 0));
        // unknown bound keeps its move but never hits
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'h30, 4, 1,
                                      tsc_pkg::BoundUnknown, 5, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h30, 0, 0, 0, 0, 0,
                                      -10, 10, 0));
        pending_q.push_back(make_word(tsc_pkg::KindBest, 64'h30, 0, 0, 0, 0, 0, 0, 0, 0));
        // suppressed record, spare kinds, clear then a query
        pending_q.push_back(make_word(tsc_pkg::KindRecord, 64'h40, 9, 1,
                                      tsc_pkg::BoundExact, 3, 0, 0, 0, 1));
        pending_q.push_back(make_word(tsc_pkg::KindProbe, 64'h40, 0, 0, 0, 0, 0,
                                      -10, 10, 0));
        pending_q.push_back(make_word(KindSpareA, 64'h10, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(KindSpareB, 64'h10, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindClear, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_word(tsc_pkg::KindBest, 64'h10, 0, 0, 0, 0, 0, 0, 0, 0));
      end
      for (int n = 0; n < 282; n++) pending_q.push_back(rand_word());
      drain();
    end

    $display("run covered %0d words over four threshold/empty-code settings and stall mixes",
             accepted_n);
    $display("%0d answers checked, %0d score hits, %0d moves found",
             answered_n, hits_n, found_n);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/tsc_pkg.sv
rtl/core/tsc_front.sv
rtl/core/tsc_back.sv
rtl/core/two_slot_score_cache.sv
tb/sv/two_slot_score_cache_tb.sv
